FILE: rtl/m4i_pkg.sv
// ----------------------------------------------------------------------------
// m4i_pkg
// Shared widths, command/status types and index tables for the 4x4 inverse.
// ----------------------------------------------------------------------------
`default_nettype none

package m4i_pkg;

  localparam int FRAC_BITS = 16;
  localparam int ELEM_W    = 32;
  localparam int THR_W     = 31;
  localparam int MUL_W     = ELEM_W + 1;          // signed multiplier operand
  localparam int PROD_W    = 2 * MUL_W;
  localparam int PAIR_W    = 2 * ELEM_W;
  localparam int COF_W     = 3 * ELEM_W + 1;      // exact 3x3 minor
  localparam int ACC_W     = 4 * ELEM_W + 2;      // exact 4x4 determinant
  localparam int NUM_W     = COF_W + 2 * FRAC_BITS + 2;
  localparam int DEN_W     = ACC_W + ELEM_W + 1;
  localparam int REM_W     = ((NUM_W > DEN_W) ? NUM_W : DEN_W) + 1;
  localparam int QUO_W     = ELEM_W;

  typedef enum logic [2:0] {
    MUL_AB, MUL_PLO, MUL_PHI, MUL_C0, MUL_C1, MUL_C2
  } mul_sel_t;

  typedef enum logic [1:0] {
    ACC_NONE, ACC_CLR, ACC_ADD, ACC_SUB
  } acc_op_t;

  typedef enum logic [1:0] {
    DIV_NONE, DIV_INIT, DIV_OVF, DIV_STEP
  } div_op_t;

  typedef struct packed {
    logic [3:0] addr_a;
    logic [3:0] addr_b;
    mul_sel_t   mul_sel;
    logic       pair_load;
    acc_op_t    acc_op;
    logic [1:0] acc_shift;   // in 32-bit words
    logic [3:0] cof_idx;
    logic       cof_wr;
    logic       abs_load;
    logic       sing_load;
    div_op_t    div_op;
    logic       out_load;
    logic [3:0] out_k;
  } dp_cmd_t;

  typedef struct packed {
    logic sing;
  } dp_stat_t;

  // Six terms of a 3x3 determinant: first(row0) * second(row1) * third(row2).
  localparam logic [1:0] TRI_B_COL [6] = '{2'd1, 2'd2, 2'd0, 2'd2, 2'd0, 2'd1};
  localparam logic [1:0] TRI_C_COL [6] = '{2'd2, 2'd1, 2'd2, 2'd0, 2'd1, 2'd0};
  localparam logic       TRI_NEG   [6] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1};

  // Matrix address of minor element (sr, sc) with row/col removed.
  function automatic logic [3:0] sub_addr(input logic [1:0] row, input logic [1:0] col,
                                          input logic [1:0] sr, input logic [1:0] sc);
    logic [1:0] r;
    logic [1:0] c;
    r = (sr >= row) ? sr + 2'd1 : sr;
    c = (sc >= col) ? sc + 2'd1 : sc;
    return {r, c};
  endfunction

endpackage

`default_nettype wire

FILE: rtl/m4i_stream_if.sv
// ----------------------------------------------------------------------------
// m4i stream interfaces
// Load channel (matrix elements in) and result channel (inverse elements out).
// ----------------------------------------------------------------------------
`default_nettype none

interface m4i_load_if;
  logic              valid;
  logic              ready;
  logic [1:0]        row_index;
  logic [1:0]        col_index;
  logic signed [31:0] element_value;
  logic              load_done;
  modport source(output valid, row_index, col_index, element_value, load_done,
                 input ready);
  modport sink(input valid, row_index, col_index, element_value, load_done,
               output ready);
endinterface

interface m4i_result_if;
  logic              valid;
  logic              ready;
  logic [1:0]        out_row;
  logic [1:0]        out_col;
  logic signed [31:0] inverse_value;
  logic              is_singular;
  logic              last_element;
  modport source(output valid, out_row, out_col, inverse_value, is_singular,
                 last_element, input ready);
  modport sink(input valid, out_row, out_col, inverse_value, is_singular,
               last_element, output ready);
endinterface

`default_nettype wire

FILE: rtl/matrix4_inverse_cofactor.sv
// ----------------------------------------------------------------------------
// matrix4_inverse_cofactor
// 4x4 matrix inverse by adjugate, signed Q16.16, exact cofactors and divide.
// ----------------------------------------------------------------------------
// Usage:
//  - load_ch: one item per matrix element (row, col, value). Items without
//    load_done only write the matrix store.
//  - The item with load_done writes its element and starts the inversion;
//    load_ch.ready stays low until the sixteenth result has been taken.
//  - Cofactors: 16 x 6 terms on the one shared 33x33 multiplier, each
//    cofactor followed by a write to the cofactor file; then the determinant.
//  - Each result then needs a 32-step restoring divide; the next divide
//    starts only after the previous result has been taken.
//  - A singular matrix (|det| below singular_threshold, or zero) skips the
//    divides: sixteen zero items with is_singular set.
//  - Results leave in column-major order; last_element marks the sixteenth.
//  - result_ch is a registered output; a stall holds the item and the
//    sequencer until ready returns.
//  - cfg_write_en/cfg_write_data set singular_threshold; write it while idle.
//  - Reset (rst, synchronous) returns to idle and sets the threshold to 1;
//    the matrix store is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix4_inverse_cofactor (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write_en,
  input  logic [m4i_pkg::THR_W-1:0]   cfg_write_data,
  m4i_load_if.sink                    load_ch,
  m4i_result_if.source                result_ch
);

  m4i_pkg::dp_cmd_t  cmd;
  m4i_pkg::dp_stat_t stat;
  logic              in_ready;
  logic              accept;

  assign load_ch.ready = in_ready;
  assign accept        = load_ch.valid && in_ready;

  // sequencer
  m4i_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (accept && load_ch.load_done),
    .out_ready (result_ch.ready),
    .stat      (stat),
    .cmd       (cmd),
    .in_ready  (in_ready),
    .out_valid (result_ch.valid)
  );

  // arithmetic and storage
  m4i_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (accept),
    .wr_addr   ({load_ch.row_index, load_ch.col_index}),
    .wr_data   (load_ch.element_value),
    .cfg_we    (cfg_write_en),
    .cfg_data  (cfg_write_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_row   (result_ch.out_row),
    .out_col   (result_ch.out_col),
    .out_value (result_ch.inverse_value),
    .out_sing  (result_ch.is_singular),
    .out_last  (result_ch.last_element)
  );

  // no new load while a result is pending
  a_no_load_during_output: assert property (@(posedge clk) disable iff (rst)
    result_ch.valid |-> !load_ch.ready)
    else $error("load accepted while result pending");

  // singular results carry zero
  a_singular_zero: assert property (@(posedge clk) disable iff (rst)
    (result_ch.valid && result_ch.is_singular) |-> (result_ch.inverse_value == '0))
    else $error("nonzero value on singular result");

  // last item is element (3,3)
  a_last_pos: assert property (@(posedge clk) disable iff (rst)
    (result_ch.valid && result_ch.last_element) |->
      (result_ch.out_row == 2'd3 && result_ch.out_col == 2'd3))
    else $error("last item at wrong position");

  // taking the last result frees the load channel
  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    (result_ch.valid && result_ch.ready && result_ch.last_element) |=> load_ch.ready)
    else $error("load channel not freed after last result");

endmodule

`default_nettype wire

FILE: rtl/m4i_dpath.sv
// ----------------------------------------------------------------------------
// m4i_dpath
// Matrix store, shared 33x33 multiplier, wide accumulator, cofactor file,
// restoring divider and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module m4i_dpath (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  wr_en,
  input  logic [3:0]                            wr_addr,
  input  logic signed [m4i_pkg::ELEM_W-1:0]     wr_data,
  input  logic                                  cfg_we,
  input  logic [m4i_pkg::THR_W-1:0]             cfg_data,
  input  m4i_pkg::dp_cmd_t                      cmd,
  output m4i_pkg::dp_stat_t                     stat,
  output logic [1:0]                            out_row,
  output logic [1:0]                            out_col,
  output logic signed [m4i_pkg::ELEM_W-1:0]     out_value,
  output logic                                  out_sing,
  output logic                                  out_last
);

  logic [m4i_pkg::ELEM_W-1:0]        mem [16];
  logic signed [m4i_pkg::ELEM_W-1:0] rd_a;
  logic signed [m4i_pkg::ELEM_W-1:0] rd_b;
  logic [m4i_pkg::THR_W-1:0]         thr;

  logic signed [m4i_pkg::MUL_W-1:0]  mx;
  logic signed [m4i_pkg::MUL_W-1:0]  my;
  logic signed [m4i_pkg::PROD_W-1:0] prod;
  logic [m4i_pkg::PAIR_W-1:0]        pair;
  logic signed [m4i_pkg::ACC_W-1:0]  acc;
  logic signed [m4i_pkg::ACC_W-1:0]  addend;
  logic [m4i_pkg::COF_W-1:0]         cof_mem [16];
  logic [m4i_pkg::COF_W-1:0]         cof_rd;
  logic [m4i_pkg::COF_W-1:0]         cof_abs;
  logic [m4i_pkg::ACC_W-1:0]         absdet;
  logic                              det_neg;
  logic                              sing;
  logic [m4i_pkg::REM_W-1:0]         den;
  logic [m4i_pkg::REM_W-1:0]         rem;
  logic [m4i_pkg::REM_W-1:0]         rem2;
  logic                              ge;
  logic [m4i_pkg::QUO_W-1:0]         quo;
  logic                              qneg;
  logic                              ovf;
  logic [m4i_pkg::QUO_W:0]           mag;
  logic [m4i_pkg::ELEM_W-1:0]        sat;
  logic [m4i_pkg::ACC_W-1:0]         lim;

  // matrix store, two registered read ports
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_a <= mem[cmd.addr_a];
    rd_b <= mem[cmd.addr_b];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= m4i_pkg::THR_W'(1);
    end else if (cfg_we) begin
      thr <= cfg_data;
    end
  end

  assign cof_rd = cof_mem[cmd.cof_idx];

  always_comb begin
    my = m4i_pkg::MUL_W'(rd_a);
    case (cmd.mul_sel)
      m4i_pkg::MUL_AB: begin
        mx = m4i_pkg::MUL_W'(rd_a);
        my = m4i_pkg::MUL_W'(rd_b);
      end
      m4i_pkg::MUL_PLO: mx = {1'b0, pair[31:0]};
      m4i_pkg::MUL_PHI: mx = m4i_pkg::MUL_W'($signed(pair[63:32]));
      m4i_pkg::MUL_C0:  mx = {1'b0, cof_rd[31:0]};
      m4i_pkg::MUL_C1:  mx = {1'b0, cof_rd[63:32]};
      m4i_pkg::MUL_C2:  mx = $signed(cof_rd[96:64]);
      default:          mx = '0;
    endcase
  end

  assign addend = m4i_pkg::ACC_W'(prod) <<< {cmd.acc_shift, 5'd0};

  always_ff @(posedge clk) begin
    prod <= mx * my;
    if (cmd.pair_load) begin
      pair <= prod[m4i_pkg::PAIR_W-1:0];
    end
    case (cmd.acc_op)
      m4i_pkg::ACC_CLR: acc <= '0;
      m4i_pkg::ACC_ADD: acc <= acc + addend;
      m4i_pkg::ACC_SUB: acc <= acc - addend;
      default:          acc <= acc;
    endcase
    if (cmd.cof_wr) begin
      cof_mem[cmd.cof_idx] <= acc[m4i_pkg::COF_W-1:0];
    end
  end

  assign lim     = m4i_pkg::ACC_W'(thr) << (3 * m4i_pkg::FRAC_BITS);
  assign cof_abs = cof_rd[m4i_pkg::COF_W-1] ? -cof_rd : cof_rd;
  assign rem2    = rem << 1;
  assign ge      = rem2 >= den;

  always_ff @(posedge clk) begin
    if (cmd.abs_load) begin
      absdet  <= acc[m4i_pkg::ACC_W-1] ? m4i_pkg::ACC_W'(-acc) : m4i_pkg::ACC_W'(acc);
      det_neg <= acc[m4i_pkg::ACC_W-1];
    end
    if (cmd.sing_load) begin
      sing <= (absdet == '0) || (absdet < lim);
      den  <= m4i_pkg::REM_W'(absdet) << (m4i_pkg::QUO_W + 1);
    end
    case (cmd.div_op)
      m4i_pkg::DIV_INIT: begin
        rem  <= (m4i_pkg::REM_W'(cof_abs) << (2 * m4i_pkg::FRAC_BITS + 1))
                + m4i_pkg::REM_W'(absdet);
        qneg <= cof_rd[m4i_pkg::COF_W-1] ^ det_neg;
        quo  <= '0;
      end
      m4i_pkg::DIV_OVF: ovf <= rem >= den;
      m4i_pkg::DIV_STEP: begin
        rem <= ge ? rem2 - den : rem2;
        quo <= {quo[m4i_pkg::QUO_W-2:0], ge};
      end
      default: ;
    endcase
  end

  // round-to-nearest already folded into the numerator; saturate here
  always_comb begin
    mag = ovf ? {1'b1, {m4i_pkg::QUO_W{1'b0}}} : {1'b0, quo};
    if (qneg) begin
      sat = (mag > 33'h0_8000_0000) ? 32'h8000_0000 : 32'(-mag);
    end else begin
      sat = (mag > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_value <= sing ? '0 : sat;
      out_row   <= cmd.out_k[1:0];
      out_col   <= cmd.out_k[3:2];
      out_sing  <= sing;
      out_last  <= cmd.out_k == 4'd15;
    end
  end

  assign stat.sing = sing;

endmodule

`default_nettype wire

FILE: rtl/m4i_ctrl.sv
// ----------------------------------------------------------------------------
// m4i_ctrl
// Sequencer: cofactors, determinant, singular check, per-element divide or zero result.
// ----------------------------------------------------------------------------
`default_nettype none

module m4i_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              out_ready,
  input  m4i_pkg::dp_stat_t stat,
  output m4i_pkg::dp_cmd_t  cmd,
  output logic              in_ready,
  output logic              out_valid
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_COF, ST_COF_WR, ST_DET, ST_ABS, ST_CHK, ST_SEL,
    ST_DIV_INIT, ST_DIV_OVF, ST_DIV_STEP, ST_LOAD, ST_OUT
  } state_t;

  state_t     state;
  logic [3:0] idx;     // cofactor index, then det column
  logic [2:0] term;    // term of the 3x3 determinant
  logic [2:0] step;
  logic [4:0] bitn;
  logic [3:0] k;       // result counter
  logic [1:0] row;
  logic [1:0] col;
  logic       parity;

  assign row      = idx[3:2];
  assign col      = idx[1:0];
  assign parity   = idx[2] ^ idx[0];
  assign in_ready = state == ST_IDLE;

  always_comb begin
    cmd           = '0;
    cmd.mul_sel   = m4i_pkg::MUL_AB;
    cmd.acc_op    = m4i_pkg::ACC_NONE;
    cmd.div_op    = m4i_pkg::DIV_NONE;
    cmd.out_k     = k;
    case (state)
      ST_COF: begin
        cmd.addr_a = (step == 3'd0)
                     ? m4i_pkg::sub_addr(row, col, 2'd1, m4i_pkg::TRI_B_COL[term])
                     : m4i_pkg::sub_addr(row, col, 2'd0, term[2:1]);
        cmd.addr_b = m4i_pkg::sub_addr(row, col, 2'd2, m4i_pkg::TRI_C_COL[term]);
        case (step)
          3'd0: if (term == 3'd0) cmd.acc_op = m4i_pkg::ACC_CLR;
          3'd1: cmd.mul_sel = m4i_pkg::MUL_AB;
          3'd2: cmd.pair_load = 1'b1;
          3'd3: cmd.mul_sel = m4i_pkg::MUL_PLO;
          3'd4: begin
            cmd.mul_sel = m4i_pkg::MUL_PHI;
            cmd.acc_op  = (m4i_pkg::TRI_NEG[term] ^ parity) ? m4i_pkg::ACC_SUB
                                                            : m4i_pkg::ACC_ADD;
          end
          3'd5: begin
            cmd.acc_shift = 2'd1;
            cmd.acc_op    = (m4i_pkg::TRI_NEG[term] ^ parity) ? m4i_pkg::ACC_SUB
                                                              : m4i_pkg::ACC_ADD;
          end
          default: ;
        endcase
      end
      ST_COF_WR: begin
        cmd.cof_idx = idx;
        cmd.cof_wr  = 1'b1;
      end
      ST_DET: begin
        cmd.addr_a  = {2'b00, idx[1:0]};
        cmd.cof_idx = {2'b00, idx[1:0]};
        case (step)
          3'd0: if (idx[1:0] == 2'd0) cmd.acc_op = m4i_pkg::ACC_CLR;
          3'd1: cmd.mul_sel = m4i_pkg::MUL_C0;
          3'd2: begin
            cmd.mul_sel = m4i_pkg::MUL_C1;
            cmd.acc_op  = m4i_pkg::ACC_ADD;
          end
          3'd3: begin
            cmd.mul_sel   = m4i_pkg::MUL_C2;
            cmd.acc_op    = m4i_pkg::ACC_ADD;
            cmd.acc_shift = 2'd1;
          end
          3'd4: begin
            cmd.acc_op    = m4i_pkg::ACC_ADD;
            cmd.acc_shift = 2'd2;
          end
          default: ;
        endcase
      end
      ST_ABS:      cmd.abs_load = 1'b1;
      ST_CHK:      cmd.sing_load = 1'b1;
      ST_DIV_INIT: begin
        cmd.cof_idx = k;   // cofactor (col, row) of output k sits at index k
        cmd.div_op  = m4i_pkg::DIV_INIT;
      end
      ST_DIV_OVF:  cmd.div_op = m4i_pkg::DIV_OVF;
      ST_DIV_STEP: cmd.div_op = m4i_pkg::DIV_STEP;
      ST_LOAD:     cmd.out_load = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      idx       <= '0;
      term      <= '0;
      step      <= '0;
      bitn      <= '0;
      k         <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_COF;
            idx   <= '0;
            term  <= '0;
            step  <= '0;
          end
        end
        ST_COF: begin
          if (step == 3'd5) begin
            step <= '0;
            if (term == 3'd5) begin
              term  <= '0;
              state <= ST_COF_WR;
            end else begin
              term <= term + 3'd1;
            end
          end else begin
            step <= step + 3'd1;
          end
        end
        ST_COF_WR: begin
          idx <= idx + 4'd1;
          if (idx == 4'd15) begin
            state <= ST_DET;
          end else begin
            state <= ST_COF;
          end
        end
        ST_DET: begin
          if (step == 3'd4) begin
            step <= '0;
            if (idx[1:0] == 2'd3) begin
              state <= ST_ABS;
            end else begin
              idx <= idx + 4'd1;
            end
          end else begin
            step <= step + 3'd1;
          end
        end
        ST_ABS: state <= ST_CHK;
        ST_CHK: begin
          k     <= '0;
          state <= ST_SEL;
        end
        ST_SEL:      state <= stat.sing ? ST_LOAD : ST_DIV_INIT;
        ST_DIV_INIT: state <= ST_DIV_OVF;
        ST_DIV_OVF: begin
          bitn  <= '0;
          state <= ST_DIV_STEP;
        end
        ST_DIV_STEP: begin
          bitn <= bitn + 5'd1;
          if (bitn == 5'd31) begin
            state <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          out_valid <= 1'b1;
          state     <= ST_OUT;
        end
        ST_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            k         <= k + 4'd1;
            state     <= (k == 4'd15) ? ST_IDLE : ST_SEL;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: tb/m4i_inverse_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m4i_inverse_checker
// Watches the load and result channels of the 4x4 inverse, keeps its own
// copy of the matrix and threshold, predicts every inverse item and compares.
// ----------------------------------------------------------------------------
module m4i_inverse_checker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write_en,
  input  logic [m4i_pkg::THR_W-1:0] cfg_write_data,
  m4i_load_if                       load_ch,
  m4i_result_if                     result_ch,
  output int                        fail_count,
  output int                        pending
);

  typedef logic signed [255:0] swide_t;
  typedef logic [255:0] uwide_t;

  typedef struct packed {
    logic [1:0]         row;
    logic [1:0]         col;
    logic signed [31:0] value;
    logic               sing;
    logic               last;
  } inv_elem_t;

  logic signed [31:0] matrix_copy [16];
  logic [30:0]        threshold;
  inv_elem_t          inverse_queue [$];

  initial begin
    fail_count = 0;
    pending    = 0;
    threshold  = 31'd1;
    foreach (matrix_copy[i]) matrix_copy[i] = '0;
  end

  function automatic swide_t cofactor_of(input int row, input int col);
    swide_t a [9];
    swide_t d;
    int k;
    k = 0;
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        if (i != row && j != col) begin
          a[k] = swide_t'(matrix_copy[i*4+j]);
          k++;
        end
      end
    end
    d = a[0] * (a[4]*a[8] - a[5]*a[7]) - a[1] * (a[3]*a[8] - a[5]*a[6])
        + a[2] * (a[3]*a[7] - a[4]*a[6]);
    if (((row + col) & 1) != 0) d = -d;
    return d;
  endfunction

  // Adjugate / determinant, rounded half away from zero, saturated.
  task automatic predict_inverse();
    swide_t    cof [4][4];
    swide_t    det;
    swide_t    num;
    uwide_t    absdet, limit, mag_num, quo;
    logic      sing, neg;
    inv_elem_t e;
    det = '0;
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++) cof[i][j] = cofactor_of(i, j);
    for (int j = 0; j < 4; j++) det = det + cof[0][j] * swide_t'(matrix_copy[j]);
    absdet = det[255] ? uwide_t'(-det) : uwide_t'(det);
    limit  = uwide_t'(threshold) << (3 * m4i_pkg::FRAC_BITS);
    sing   = (det == 0) || (absdet < limit);
    for (int k = 0; k < 16; k++) begin
      e.row   = 2'(k & 3);
      e.col   = 2'(k >> 2);
      e.sing  = sing;
      e.last  = (k == 15);
      e.value = '0;
      if (!sing) begin
        num     = cof[k>>2][k&3];
        neg     = num[255] != det[255];
        mag_num = num[255] ? uwide_t'(-num) : uwide_t'(num);
        quo     = ((mag_num << (2 * m4i_pkg::FRAC_BITS + 1)) + absdet) / (absdet << 1);
        if (neg) begin
          if (quo > uwide_t'(33'h0_8000_0000)) quo = uwide_t'(33'h0_8000_0000);
          e.value = 32'(-quo);
        end else begin
          if (quo > uwide_t'(32'h7FFF_FFFF)) quo = uwide_t'(32'h7FFF_FFFF);
          e.value = 32'(quo);
        end
      end
      inverse_queue.push_back(e);
    end
  endtask

  always @(posedge clk) begin
    inv_elem_t exp_e;
    if (rst) begin
      threshold <= 31'd1;
    end else begin
      if (cfg_write_en) threshold <= cfg_write_data;
      if (load_ch.valid && load_ch.ready) begin
        matrix_copy[{load_ch.row_index, load_ch.col_index}] = load_ch.element_value;
        if (load_ch.load_done) predict_inverse();
      end
      if (result_ch.valid && result_ch.ready) begin
        if (inverse_queue.size() == 0) begin
          $display("%0t: unexpected item row=%0d col=%0d value=%h", $time,
                   result_ch.out_row, result_ch.out_col, result_ch.inverse_value);
          fail_count++;
        end else begin
          exp_e = inverse_queue.pop_front();
          if (result_ch.out_row !== exp_e.row || result_ch.out_col !== exp_e.col ||
              result_ch.inverse_value !== exp_e.value ||
              result_ch.is_singular !== exp_e.sing ||
              result_ch.last_element !== exp_e.last) begin
            $display("%0t: mismatch expected r=%0d c=%0d v=%h s=%b l=%b actual r=%0d c=%0d v=%h s=%b l=%b",
                     $time, exp_e.row, exp_e.col, exp_e.value, exp_e.sing, exp_e.last,
                     result_ch.out_row, result_ch.out_col, result_ch.inverse_value,
                     result_ch.is_singular, result_ch.last_element);
            fail_count++;
          end
        end
      end
    end
    pending = inverse_queue.size();
  end

endmodule

FILE: tb/tb_matrix4_inverse_cofactor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_matrix4_inverse_cofactor
// Loads directed and random matrices into the 4x4 inverse under several
// threshold settings and idle/stall mixes; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_matrix4_inverse_cofactor;

  localparam int LIMIT_CYCLES = 1500000;

  logic        clk;
  logic        rst;
  logic        cfg_write_en;
  logic [30:0] cfg_write_data;
  int          fail_count;
  int          pending;

  // idle and stall mix, set per phase by the stimulus
  int idle_pct;
  int stall_pct;
  // long receiver hold: stimulus bumps the request, ready process counts it
  int hold_req;
  int hold_seen;
  int hold_left;
  int cycles;

  m4i_load_if   load_ch ();
  m4i_result_if result_ch ();

  matrix4_inverse_cofactor i_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .load_ch        (load_ch),
    .result_ch      (result_ch)
  );

  m4i_inverse_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .load_ch        (load_ch),
    .result_ch      (result_ch),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  always begin
    clk = 1'b1; #4;
    clk = 1'b0; #4;
  end

  // all inputs known from time zero
  initial begin
    rst                     = 1'b1;
    cfg_write_en            = 1'b0;
    cfg_write_data          = '0;
    load_ch.valid           = 1'b0;
    load_ch.row_index       = '0;
    load_ch.col_index       = '0;
    load_ch.element_value   = '0;
    load_ch.load_done       = 1'b0;
    result_ch.ready         = 1'b0;
    idle_pct                = 0;
    stall_pct               = 0;
    hold_req                = 0;
    hold_seen               = 0;
    hold_left               = 0;
    cycles                  = 0;
  end

  // timeout
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // receiver: random stalls, plus the long hold when asked for
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = 1500;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // one load item; idle gaps before it, then hold valid until taken
  task automatic load_element(input logic [1:0] r, input logic [1:0] c,
                              input logic [31:0] v, input logic done);
    while ($urandom_range(99) < idle_pct) begin
      load_ch.valid <= 1'b0;
      @(posedge clk);
    end
    load_ch.valid         <= 1'b1;
    load_ch.row_index     <= r;
    load_ch.col_index     <= c;
    load_ch.element_value <= v;
    load_ch.load_done     <= done;
    do @(posedge clk); while (!load_ch.ready);
  endtask

  // register write only once the block is drained; the task first lets the
  // checker queue the items of the last load
  task automatic set_threshold(input logic [30:0] v);
    load_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= v;
    @(posedge clk);
    cfg_write_en   <= 1'b0;
  endtask

  function automatic logic [31:0] pick_value(input int r, input int c);
    logic [31:0] v;
    case ($urandom_range(4))
      0: v = $urandom;
      1: v = 32'($signed($urandom_range(262144)) - 131072);
      2: case ($urandom_range(4))
           0: v = 32'h7FFF_FFFF;
           1: v = 32'h8000_0000;
           2: v = 32'h0000_0000;
           3: v = 32'h0000_0001;
           default: v = 32'hFFFF_FFFF;
         endcase
      default: v = (r == c) ? 32'($urandom_range(8) + 1) << 16
                            : 32'($signed($urandom_range(32768)) - 16384);
    endcase
    return v;
  endfunction

  // random matrix: mostly a full rewrite, else a few overwritten entries
  task automatic random_matrix(inout int items);
    int n;
    int r;
    int c;
    if ($urandom_range(99) < 60) begin
      for (int k = 0; k < 16; k++)
        load_element(2'(k >> 2), 2'(k & 3), pick_value(k >> 2, k & 3), k == 15);
      items += 16;
    end else begin
      n = $urandom_range(6) + 1;
      for (int k = 0; k < n; k++) begin
        r = $urandom_range(3);
        c = $urandom_range(3);
        load_element(2'(r), 2'(c), pick_value(r, c), k == n - 1);
      end
      items += n;
    end
  endtask

  initial begin
    int items;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: zero threshold, identity, then singular and extreme reloads
    set_threshold(31'd0);
    for (int k = 0; k < 16; k++)
      load_element(2'(k >> 2), 2'(k & 3), (k % 5 == 0) ? 32'h0001_0000 : 32'h0, k == 15);
    load_element(2'd0, 2'd0, 32'h0, 1'b1);           // det exactly zero
    load_element(2'd0, 2'd0, 32'h7FFF_FFFF, 1'b1);   // huge pivot
    load_element(2'd3, 2'd3, 32'h8000_0000, 1'b1);
    load_element(2'd1, 2'd2, 32'hFFFF_FFFF, 1'b1);
    set_threshold(31'h7FFF_FFFF);
    load_element(2'd2, 2'd1, 32'h0000_0001, 1'b1);
    load_element(2'd0, 2'd0, 32'h0001_0000, 1'b1);

    items = 0;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  set_threshold(31'd1); end
        1: begin idle_pct = 70; stall_pct = 0;  set_threshold(31'($urandom_range(4))); end
        2: begin
          idle_pct  = 0;
          stall_pct = 70;
          set_threshold(31'($urandom >> $urandom_range(31, 8)));
        end
        default: begin idle_pct = 10; stall_pct = 10; set_threshold(31'h7FFF_FFFF); end
      endcase
      if (ph == 0) hold_req++;
      while (items < (ph + 1) * 65) random_matrix(items);
    end
    load_ch.valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/m4i_pkg.sv
rtl/m4i_stream_if.sv
rtl/m4i_dpath.sv
rtl/m4i_ctrl.sv
rtl/matrix4_inverse_cofactor.sv
tb/m4i_inverse_checker.sv
tb/tb_matrix4_inverse_cofactor.sv
